FILE: rtl/core/double_ended_queue_with_sort_macros.svh
// Assertion macros shared by the checker of the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SORT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SORT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define DEQS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DEQS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/deqs_pkg.sv
// Shared types and constants of the double-ended queue with sort.
package deqs_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 5;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 40;

   typedef enum logic [2:0] {
      OP_PUSH_HEAD = 3'd0,
      OP_PUSH_TAIL = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_POP_TAIL  = 3'd3,
      OP_CLEAR     = 3'd4,
      OP_SORT      = 3'd5,
      OP_LIST_HEAD = 3'd6,
      OP_LIST_TAIL = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_EMPTY      = 2'd1,
      STAT_FULL       = 2'd2,
      STAT_LIST_EMPTY = 2'd3
   } stat_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_EXEC,
      CMD_RESULT,
      CMD_SORT_START,
      CMD_SORT_LDI,
      CMD_SORT_CMP,
      CMD_SORT_WRI,
      CMD_LIST_START,
      CMD_LIST_EMIT
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   lt2;
      logic   j_last;
      logic   i_last;
      logic   k_last;
      logic   out_free;
   } dp_status_type;

endpackage

FILE: rtl/core/deqs_dpath.sv
// Datapath of the double-ended queue: element memory, ring pointers, sort and list walkers.
module deqs_dpath
   import deqs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [REQ_W-1:0]  req_tdata,
   output dp_status_type     stat,
   output logic [RSP_W-1:0]  rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic signed [VALUE_W-1:0] mem [DEPTH];

   op_type                    op_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic [AW-1:0]             head_ff;
   logic [CW-1:0]             count_ff;
   stat_type                  status_ff;
   logic signed [VALUE_W-1:0] cur_ff;
   logic signed [VALUE_W-1:0] rd_ff;
   logic [CW-1:0]             i_ff;
   logic [CW-1:0]             j_ff;
   logic [CW-1:0]             k_ff;
   logic signed [VALUE_W-1:0] out_value_ff;
   stat_type                  out_status_ff;
   logic [CW-1:0]             out_count_ff;
   logic                      out_last_ff;
   logic                      out_valid_ff;
   logic                      out_valid_in;

   logic                      empty;
   logic                      full;
   logic                      swap;
   stat_type                  exec_status;
   logic                      rd_en;
   logic [AW-1:0]             rd_off;
   logic [AW-1:0]             rd_slot;
   logic                      wr_en;
   logic [AW-1:0]             wr_off;
   logic [AW-1:0]             wr_slot;
   logic signed [VALUE_W-1:0] wr_data;
   logic                      out_load;

   function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [AW-1:0] off);
      logic [AW:0] s;
      s = {1'b0, h} + {1'b0, off};
      if (s >= (AW+1)'(DEPTH)) begin
         s = s - (AW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] list_off(input op_type op, input logic [CW-1:0] cnt,
                                              input logic [CW-1:0] kv);
      logic [CW-1:0] back;
      back = cnt - CW'(1) - kv;
      return (op == OP_LIST_TAIL) ? back[AW-1:0] : kv[AW-1:0];
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff >= CW'(DEPTH));
   assign swap  = (cur_ff > rd_ff);

   assign stat.op       = op_ff;
   assign stat.empty    = empty;
   assign stat.full     = full;
   assign stat.lt2      = (count_ff < CW'(2));
   assign stat.j_last   = ({1'b0, j_ff} + (CW+1)'(1)) == {1'b0, count_ff};
   assign stat.i_last   = ({1'b0, i_ff} + (CW+1)'(2)) >= {1'b0, count_ff};
   assign stat.k_last   = ({1'b0, k_ff} + (CW+1)'(1)) == {1'b0, count_ff};
   assign stat.out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      case (op_ff)
         OP_PUSH_HEAD, OP_PUSH_TAIL: exec_status = full ? STAT_FULL : STAT_OK;
         OP_POP_HEAD, OP_POP_TAIL:   exec_status = empty ? STAT_EMPTY : STAT_OK;
         OP_LIST_HEAD, OP_LIST_TAIL: exec_status = empty ? STAT_LIST_EMPTY : STAT_OK;
         default:                    exec_status = STAT_OK;
      endcase
   end

   always_comb begin
      rd_en  = 1'b1;
      rd_off = '0;
      case (cmd)
         CMD_SORT_START: rd_off = '0;
         CMD_SORT_LDI:   rd_off = j_ff[AW-1:0];
         CMD_SORT_CMP:   rd_off = AW'(j_ff + CW'(1));
         CMD_SORT_WRI:   rd_off = AW'(i_ff + CW'(1));
         CMD_LIST_START: rd_off = list_off(op_ff, count_ff, '0);
         CMD_LIST_EMIT:  rd_off = list_off(op_ff, count_ff, k_ff + CW'(1));
         default:        rd_en  = 1'b0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_off  = '0;
      wr_data = val_ff;
      case (cmd)
         CMD_EXEC: begin
            if (op_ff == OP_PUSH_HEAD && !full) begin
               wr_en  = 1'b1;
               wr_off = AW'(DEPTH - 1);
            end else if (op_ff == OP_PUSH_TAIL && !full) begin
               wr_en  = 1'b1;
               wr_off = count_ff[AW-1:0];
            end
         end
         CMD_SORT_CMP: begin
            wr_en   = swap;
            wr_off  = j_ff[AW-1:0];
            wr_data = cur_ff;
         end
         CMD_SORT_WRI: begin
            wr_en   = 1'b1;
            wr_off  = i_ff[AW-1:0];
            wr_data = cur_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   assign rd_slot  = wrap(head_ff, rd_off);
   assign wr_slot  = wrap(head_ff, wr_off);
   assign out_load = (cmd == CMD_RESULT) || (cmd == CMD_LIST_EMIT);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd == CMD_EXEC) begin
            case (op_ff)
               OP_PUSH_HEAD: begin
                  if (!full) begin
                     head_ff  <= wr_slot;
                     count_ff <= count_ff + CW'(1);
                  end
               end
               OP_PUSH_TAIL: begin
                  if (!full) begin
                     count_ff <= count_ff + CW'(1);
                  end
               end
               OP_POP_HEAD: begin
                  if (!empty) begin
                     head_ff  <= wrap(head_ff, AW'(1));
                     count_ff <= count_ff - CW'(1);
                  end
               end
               OP_POP_TAIL: begin
                  if (!empty) begin
                     count_ff <= count_ff - CW'(1);
                  end
               end
               OP_CLEAR: begin
                  head_ff  <= '0;
                  count_ff <= '0;
               end
               default: head_ff <= head_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_LOAD: begin
            op_ff  <= op_type'(req_tdata[2:0]);
            val_ff <= req_tdata[34:3];
         end
         CMD_EXEC: status_ff <= exec_status;
         CMD_SORT_START: begin
            status_ff <= exec_status;
            i_ff      <= '0;
            j_ff      <= CW'(1);
         end
         CMD_SORT_LDI: cur_ff <= rd_ff;
         CMD_SORT_CMP: begin
            if (swap) begin
               cur_ff <= rd_ff;
            end
            j_ff <= j_ff + CW'(1);
         end
         CMD_SORT_WRI: begin
            i_ff <= i_ff + CW'(1);
            j_ff <= i_ff + CW'(2);
         end
         CMD_LIST_START: k_ff <= '0;
         CMD_LIST_EMIT: begin
            out_value_ff  <= rd_ff;
            out_status_ff <= STAT_OK;
            out_count_ff  <= count_ff;
            out_last_ff   <= stat.k_last;
            k_ff          <= k_ff + CW'(1);
         end
         CMD_RESULT: begin
            out_value_ff  <= '0;
            out_status_ff <= status_ff;
            out_count_ff  <= count_ff;
            out_last_ff   <= 1'b1;
         end
         default: cur_ff <= cur_ff;
      endcase
   end

   assign rsp_tdata  = {1'b0, COUNT_W'(out_count_ff), out_status_ff, out_value_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tvalid = out_valid_ff;

endmodule

FILE: rtl/core/deqs_ctrl.sv
// Controller state machine of the double-ended queue: sequences each item's commands.
module deqs_ctrl
   import deqs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type stat,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESULT,
      ST_SORT_LDI,
      ST_SORT_CMP,
      ST_SORT_WRI,
      ST_LIST
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd      = CMD_LOAD;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.op)
               OP_SORT: begin
                  if (stat.lt2) begin
                     cmd      = CMD_EXEC;
                     state_in = ST_RESULT;
                  end else begin
                     cmd      = CMD_SORT_START;
                     state_in = ST_SORT_LDI;
                  end
               end
               OP_LIST_HEAD, OP_LIST_TAIL: begin
                  if (stat.empty) begin
                     cmd      = CMD_EXEC;
                     state_in = ST_RESULT;
                  end else begin
                     cmd      = CMD_LIST_START;
                     state_in = ST_LIST;
                  end
               end
               default: begin
                  cmd      = CMD_EXEC;
                  state_in = ST_RESULT;
               end
            endcase
         end
         ST_SORT_LDI: begin
            cmd      = CMD_SORT_LDI;
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            cmd = CMD_SORT_CMP;
            if (stat.j_last) begin
               state_in = ST_SORT_WRI;
            end
         end
         ST_SORT_WRI: begin
            cmd      = CMD_SORT_WRI;
            state_in = stat.i_last ? ST_RESULT : ST_SORT_LDI;
         end
         ST_RESULT: begin
            if (stat.out_free) begin
               cmd      = CMD_RESULT;
               state_in = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (stat.out_free) begin
               cmd = CMD_LIST_EMIT;
               if (stat.k_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_tready = ready_ff;

endmodule

FILE: rtl/core/double_ended_queue_with_sort.sv
// Top level of the bounded double-ended queue of signed values with an in-place sort.
// Push, pop and clear: accepted, applied in the cycle after, result registered once the output is free;
// a new item is taken only after the result of the last one has been registered.
// Sort of n elements: load, compare-and-exchange and write-back steps on the element memory.
// Listing of n elements: after a start step, one result per cycle while the output is not stalled.
// Synchronous reset empties the queue and sets the head to zero; no memory clearing pass.
module double_ended_queue_with_sort
   import deqs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // op[2:0], value[34:3], zero fill
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // value_res[31:0], status[33:32], count[38:34], zero
   output logic             rsp_tlast
);

   cmd_type       cmd;
   dp_status_type stat;

   deqs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   deqs_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .stat       (stat),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

endmodule

FILE: rtl/core/deqs_checker.sv
// Port-level checker of the double-ended queue, bound to the top level.
`include "double_ended_queue_with_sort_macros.svh"

module deqs_checker
   import deqs_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   logic err_result;
   logic req_fire;

   assign err_result = rsp_tvalid && (rsp_tdata[33:32] != STAT_OK);
   assign req_fire   = req_tvalid && req_tready && (req_tdata[2:0] == req_tdata[2:0]);

   `DEQS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result item changed while stalled")
   `DEQS_ASSERT_SAME(a_err_last, err_result, rsp_tlast, "error result item not marked last")
   `DEQS_ASSERT_SAME(a_err_zero, err_result, rsp_tdata[31:0] == '0, "error result item carries a value")
   `DEQS_ASSERT_NEXT(a_one_item, req_fire, !req_tready, "second item taken before the first was done")

endmodule

bind double_ended_queue_with_sort deqs_checker u_deqs_checker (.*);
